// ----- design/particle_sensor_frame_parser_assert.svh -----
// Assertion macros shared by the parser modules.
`ifndef PARTICLE_SENSOR_FRAME_PARSER_ASSERT_SVH
`define PARTICLE_SENSOR_FRAME_PARSER_ASSERT_SVH

// Checked only while out of reset.
`define PSFP_ASSERT_RST(lbl, clk_sig, rstn_sig, prop, msg) \
    lbl: assert property (@(posedge clk_sig) disable iff (!rstn_sig) prop) else $error(msg);

// Checked on every edge, reset included.
`define PSFP_ASSERT_ALWAYS(lbl, clk_sig, prop, msg) \
    lbl: assert property (@(posedge clk_sig) prop) else $error(msg);

`endif

// ----- design/psfp_pkg.sv -----
package psfp_pkg;

    localparam int FRAME_BYTES      = 24;
    localparam int POS_W            = 5;
    localparam int FIRST_VALUE_BYTE = 4;
    localparam int VALUE_COUNT      = 6;
    localparam int SLOT_W           = 3;

    localparam logic [7:0] START_BYTE = 8'h42;

    localparam logic [POS_W-1:0] CHECK_HI_POS = POS_W'(FRAME_BYTES - 2);
    localparam logic [POS_W-1:0] LAST_POS     = POS_W'(FRAME_BYTES - 1);
    localparam logic [POS_W-1:0] VALUE_FIRST  = POS_W'(FIRST_VALUE_BYTE);
    localparam logic [POS_W-1:0] VALUE_END    = POS_W'(FIRST_VALUE_BYTE + 2 * VALUE_COUNT);

    typedef logic [15:0] word_t;

    typedef struct packed {
        logic                         status;
        logic [VALUE_COUNT-1:0][15:0] values;
    } result_t;

    // Handshake between the input register and the output register.
    typedef struct packed {
        logic load;
        logic free;
    } out_ctrl_t;

endpackage

// ----- design/particle_sensor_frame_parser.sv -----
// Channel | Signals                          | Direction
// --------+----------------------------------+----------------------
// in      | in_valid, in_stall, rx_byte      | one request per byte
// out     | out_valid, out_stall, status,    | one request per frame
//         | pm1/pm2_5/pm10 _std and _env     |
// Takes one byte every cycle while in_stall is low; the last byte of a frame passes
// through the input register, then the result register, to reach the outputs.
// rst_n returns the parser to hunting and clears the position, the sum and the held last good values to zero.
// in_stall rises only when the byte that closes a frame waits on a held
// result (out_valid high and out_stall high); other bytes never stall.

`include "particle_sensor_frame_parser_assert.svh"

module particle_sensor_frame_parser
    import psfp_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [7:0]  rx_byte,
    output logic        out_valid,
    input  logic        out_stall,
    output logic        status,
    output logic [15:0] pm1_std,
    output logic [15:0] pm2_5_std,
    output logic [15:0] pm10_std,
    output logic [15:0] pm1_env,
    output logic [15:0] pm2_5_env,
    output logic [15:0] pm10_env
);

    logic       in_valid_reg, in_valid_next;
    logic [7:0] in_byte_reg;
    logic       accept;
    logic       advance;
    logic       last;
    logic       free;
    out_ctrl_t  ctrl;
    result_t    result;
    result_t    result_out;

    assign advance   = in_valid_reg && (!last || free);
    assign in_stall  = in_valid_reg && !advance;
    assign accept    = in_valid && !in_stall;
    assign ctrl.load = advance && last;
    assign ctrl.free = free;

    always_comb
    begin
        in_valid_next = in_valid_reg;
        if (accept)
        begin
            in_valid_next = 1'b1;
        end
        else if (advance)
        begin
            in_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg <= in_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            in_byte_reg <= rx_byte;
        end
    end

    psfp_parse u_parse (
        .clk    (clk),
        .rst_n  (rst_n),
        .step   (advance),
        .data   (in_byte_reg),
        .last   (last),
        .result (result)
    );

    psfp_out u_out (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctrl_in    (ctrl),
        .free       (free),
        .result_in  (result),
        .out_stall  (out_stall),
        .out_valid  (out_valid),
        .result_out (result_out)
    );

    assign status    = result_out.status;
    assign pm1_std   = result_out.values[0];
    assign pm2_5_std = result_out.values[1];
    assign pm10_std  = result_out.values[2];
    assign pm1_env   = result_out.values[3];
    assign pm2_5_env = result_out.values[4];
    assign pm10_env  = result_out.values[5];

    `PSFP_ASSERT_RST(a_stall_cause, clk, rst_n,
        in_stall |-> out_valid && out_stall && last, "input stalled without a held result")
    `PSFP_ASSERT_RST(a_byte_moves, clk, rst_n,
        in_valid_reg && !last |-> advance, "mid-frame byte held back")

endmodule

// ----- design/psfp_parse.sv -----
`include "particle_sensor_frame_parser_assert.svh"

module psfp_parse
    import psfp_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      step,
    input  logic [7:0] data,
    output logic      last,
    output result_t   result
);

    logic             in_frame_reg, in_frame_next;
    logic [POS_W-1:0] pos_reg, pos_next;
    word_t            sum_reg, sum_next;
    word_t            chk_reg, chk_next;
    word_t            words_reg [VALUE_COUNT];
    word_t            words_next [VALUE_COUNT];
    word_t            rep_reg [VALUE_COUNT];
    word_t            rep_next [VALUE_COUNT];

    logic [POS_W-1:0]  offs;
    logic [SLOT_W-1:0] slot;
    logic              in_values;
    word_t             check_word;
    logic              bad;

    assign last       = in_frame_reg && (pos_reg == LAST_POS);
    assign offs       = pos_reg - VALUE_FIRST;
    assign slot       = offs[SLOT_W:1];
    assign in_values  = (pos_reg >= VALUE_FIRST) && (pos_reg < VALUE_END);
    assign check_word = {chk_reg[15:8], data};
    assign bad        = (sum_reg != check_word);

    always_comb
    begin
        in_frame_next = in_frame_reg;
        pos_next      = pos_reg;
        sum_next      = sum_reg;
        chk_next      = chk_reg;
        words_next    = words_reg;
        rep_next      = rep_reg;
        if (step)
        begin
            if (!in_frame_reg)
            begin
                if (data == START_BYTE)
                begin
                    in_frame_next = 1'b1;
                    pos_next      = POS_W'(1);
                    sum_next      = {8'h00, START_BYTE};
                end
            end
            else
            begin
                if (pos_reg < CHECK_HI_POS)
                begin
                    sum_next = sum_reg + {8'h00, data};
                end
                if (in_values)
                begin
                    if (!offs[0])
                    begin
                        words_next[slot] = {data, 8'h00};
                    end
                    else
                    begin
                        words_next[slot] = {words_reg[slot][15:8], data};
                    end
                end
                if (pos_reg == CHECK_HI_POS)
                begin
                    chk_next = {data, 8'h00};
                end
                if (last)
                begin
                    in_frame_next = 1'b0;
                    pos_next      = '0;
                    sum_next      = '0;
                    if (!bad)
                    begin
                        rep_next = words_reg;
                    end
                end
                else
                begin
                    pos_next = pos_reg + POS_W'(1);
                end
            end
        end
    end

    always_comb
    begin
        result.status = bad;
        for (int k = 0; k < VALUE_COUNT; k++)
        begin
            result.values[k] = bad ? rep_reg[k] : words_reg[k];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_frame_reg <= 1'b0;
            pos_reg      <= '0;
            sum_reg      <= '0;
            for (int k = 0; k < VALUE_COUNT; k++)
            begin
                rep_reg[k] <= '0;
            end
        end
        else
        begin
            in_frame_reg <= in_frame_next;
            pos_reg      <= pos_next;
            sum_reg      <= sum_next;
            rep_reg      <= rep_next;
        end
    end

    always_ff @(posedge clk)
    begin
        chk_reg   <= chk_next;
        words_reg <= words_next;
    end

    `PSFP_ASSERT_RST(a_hunt_clear, clk, rst_n,
        !in_frame_reg |-> (pos_reg == '0) && (sum_reg == '0), "hunting with stale state")
    `PSFP_ASSERT_RST(a_pos_range, clk, rst_n,
        in_frame_reg |-> (pos_reg != '0) && (pos_reg <= LAST_POS), "frame position out of range")
    `PSFP_ASSERT_RST(a_start, clk, rst_n,
        step && !in_frame_reg && (data == START_BYTE) |=> in_frame_reg && (pos_reg == POS_W'(1)),
        "start byte did not open a frame")
    `PSFP_ASSERT_RST(a_end, clk, rst_n,
        step && last |=> !in_frame_reg, "frame did not close after last byte")

endmodule

// ----- design/psfp_out.sv -----
`include "particle_sensor_frame_parser_assert.svh"

module psfp_out
    import psfp_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  out_ctrl_t ctrl_in,
    output logic      free,
    input  result_t   result_in,
    input  logic      out_stall,
    output logic      out_valid,
    output result_t   result_out
);

    logic    valid_reg, valid_next;
    result_t data_reg;

    assign free       = !valid_reg || !out_stall;
    assign out_valid  = valid_reg;
    assign result_out = data_reg;

    always_comb
    begin
        valid_next = valid_reg;
        if (ctrl_in.load)
        begin
            valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl_in.load)
        begin
            data_reg <= result_in;
        end
    end

    `PSFP_ASSERT_RST(a_no_overwrite, clk, rst_n,
        !(ctrl_in.load && valid_reg && out_stall), "result overwritten while stalled")
    `PSFP_ASSERT_RST(a_load_shows, clk, rst_n,
        ctrl_in.load |=> valid_reg, "loaded result not presented")
    `PSFP_ASSERT_RST(a_free_match, clk, rst_n,
        ctrl_in.load |-> ctrl_in.free, "load without room")

endmodule
